// ----- hdl/tlm_pkg.sv -----
// ----------------------------------------------------------------------------
// tlm_pkg
// Shared types and constants of the two-list median engine.
// ----------------------------------------------------------------------------
package tlm_pkg;

  localparam int VALUE_W  = 32;
  localparam int MEDIAN_W = 33;
  localparam int MEAN_W   = 34;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element_value;
    logic                      list_select;
    logic                      last_item;
  } item_t;

endpackage

// ----- hdl/tlm_item_if.sv -----
// ----------------------------------------------------------------------------
// tlm_item_if
// Input channel: one element with its list tag and end-of-set mark.
// ----------------------------------------------------------------------------
interface tlm_item_if import tlm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] element_value;
  logic                      list_select;
  logic                      last_item;

  modport source (output valid, element_value, list_select, last_item, input ready);
  modport sink (input valid, element_value, list_select, last_item, output ready);
endinterface

// ----- hdl/tlm_result_if.sv -----
// ----------------------------------------------------------------------------
// tlm_result_if
// Output channel: both doubled medians, their sum and a status code.
// ----------------------------------------------------------------------------
interface tlm_result_if import tlm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_a_doubled;
  logic signed [MEDIAN_W-1:0] median_b_doubled;
  logic signed [MEAN_W-1:0]   mean_of_medians_quadrupled;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, median_a_doubled, median_b_doubled,
                  mean_of_medians_quadrupled, status, input ready);
  modport sink (input valid, median_a_doubled, median_b_doubled,
                mean_of_medians_quadrupled, status, output ready);
endinterface

// ----- hdl/tlm_ram.sv -----
// ----------------------------------------------------------------------------
// tlm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tlm_front.sv -----
// ----------------------------------------------------------------------------
// tlm_front
// Accepts input transfers into a two-entry queue that feeds the sorter.
// ----------------------------------------------------------------------------
module tlm_front import tlm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tlm_item_if.sink   items,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_ready
);

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  assign items.ready = (fill != 2'd2);
  assign push        = items.valid && items.ready;
  assign q_valid     = (fill != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{element_value: items.element_value,
                         list_select:   items.list_select,
                         last_item:     items.last_item};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/tlm_back.sv -----
// ----------------------------------------------------------------------------
// tlm_back
// Insertion sort of each list in RAM and median readout on the last item.
// ----------------------------------------------------------------------------
module tlm_back import tlm_pkg::*; #(
  parameter int LIST_CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_ready,
  tlm_result_if.source results
);

  localparam int IW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int CW = $clog2(LIST_CAPACITY + 1);
  localparam int AW = IW + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CMP  = 7'b0000010,
    S_PUT  = 7'b0000100,
    S_M0   = 7'b0001000,
    S_M1   = 7'b0010000,
    S_M2   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                     state;
  logic signed [VALUE_W-1:0]  cur_v;
  logic                       cur_sel;
  logic                       cur_last;
  logic [IW-1:0]              pos;
  logic [CW-1:0]              count_a;
  logic [CW-1:0]              count_b;
  logic                       overflow_seen;
  logic                       med_list;
  logic signed [VALUE_W-1:0]  hi;
  logic signed [MEDIAN_W-1:0] med_a;
  logic signed [MEDIAN_W-1:0] med_b;
  logic                       o_valid;
  logic signed [MEDIAN_W-1:0] o_med_a;
  logic signed [MEDIAN_W-1:0] o_med_b;
  logic signed [MEAN_W-1:0]   o_mean;
  logic [STATUS_W-1:0]        o_status;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [VALUE_W-1:0]         wdata;
  logic [AW-1:0]              raddr;
  logic [VALUE_W-1:0]         rdata;
  logic signed [VALUE_W-1:0]  rd_s;
  logic [CW-1:0]              n_in;
  logic [CW-1:0]              n_med;
  logic [CW-1:0]              half;
  logic                       gt;
  logic signed [MEDIAN_W-1:0] med_calc;

  tlm_ram #(.WIDTH(VALUE_W), .DEPTH(2 ** AW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_s     = $signed(rdata);
  assign n_in     = q_item.list_select ? count_b : count_a;
  assign n_med    = med_list ? count_b : count_a;
  assign half     = n_med >> 1;
  assign gt       = rd_s > cur_v;
  assign q_ready  = (state == S_IDLE);

  always_comb begin
    if (n_med == '0) begin
      med_calc = '0;
    end else if (n_med[0]) begin
      med_calc = {hi, 1'b0};
    end else begin
      med_calc = {hi[VALUE_W-1], hi} + {rd_s[VALUE_W-1], rd_s};
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = {cur_sel, pos};
    wdata = cur_v;
    raddr = {cur_sel, pos - IW'(1)};
    unique case (state)
      S_IDLE: begin
        raddr = {q_item.list_select, IW'(n_in - CW'(1))};
        waddr = {q_item.list_select, {IW{1'b0}}};
        wdata = q_item.element_value;
        we    = q_valid && (n_in == '0);
      end
      S_CMP: begin
        we    = 1'b1;
        raddr = {cur_sel, pos - IW'(2)};
        if (gt) begin
          wdata = rdata;
        end
      end
      S_PUT: begin
        we = 1'b1;
      end
      S_M0: begin
        raddr = {med_list, IW'(half)};
      end
      S_M1: begin
        raddr = {med_list, IW'(half - CW'(1))};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
      o_valid       <= 1'b0;
    end else begin
      if (results.ready && state != S_OUT) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_v    <= q_item.element_value;
            cur_sel  <= q_item.list_select;
            cur_last <= q_item.last_item;
            med_list <= 1'b0;
            if (n_in == CW'(LIST_CAPACITY)) begin
              overflow_seen <= 1'b1;
              state <= q_item.last_item ? S_M0 : S_IDLE;
            end else if (n_in == '0) begin
              if (q_item.list_select) begin
                count_b <= count_b + CW'(1);
              end else begin
                count_a <= count_a + CW'(1);
              end
              state <= q_item.last_item ? S_M0 : S_IDLE;
            end else begin
              pos   <= IW'(n_in);
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (gt) begin
            pos   <= pos - IW'(1);
            state <= (pos == IW'(1)) ? S_PUT : S_CMP;
          end else begin
            if (cur_sel) begin
              count_b <= count_b + CW'(1);
            end else begin
              count_a <= count_a + CW'(1);
            end
            state <= cur_last ? S_M0 : S_IDLE;
          end
        end
        S_PUT: begin
          if (cur_sel) begin
            count_b <= count_b + CW'(1);
          end else begin
            count_a <= count_a + CW'(1);
          end
          state <= cur_last ? S_M0 : S_IDLE;
        end
        S_M0: begin
          state <= S_M1;
        end
        S_M1: begin
          hi    <= rd_s;
          state <= S_M2;
        end
        S_M2: begin
          if (med_list) begin
            med_b <= med_calc;
            state <= S_OUT;
          end else begin
            med_a    <= med_calc;
            med_list <= 1'b1;
            state    <= S_M0;
          end
        end
        S_OUT: begin
          if (!o_valid || results.ready) begin
            o_valid  <= 1'b1;
            o_med_a  <= med_a;
            o_med_b  <= med_b;
            o_mean   <= {med_a[MEDIAN_W-1], med_a} + {med_b[MEDIAN_W-1], med_b};
            if (count_a == '0 || count_b == '0) begin
              o_status <= STATUS_EMPTY;
            end else if (overflow_seen) begin
              o_status <= STATUS_DROPPED;
            end else begin
              o_status <= STATUS_OK;
            end
            count_a       <= '0;
            count_b       <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid                      = o_valid;
  assign results.median_a_doubled           = o_med_a;
  assign results.median_b_doubled           = o_med_b;
  assign results.mean_of_medians_quadrupled = o_mean;
  assign results.status                     = o_status;

endmodule

// ----- hdl/two_list_median_engine.sv -----
// ----------------------------------------------------------------------------
// two_list_median_engine
// Sorts tagged elements into two lists and reports both medians on the last.
//
//   Channel   Direction  Payload
//   items     in         element_value, list_select, last_item
//   results   out        median_a_doubled, median_b_doubled,
//                        mean_of_medians_quadrupled, status
//
// An element that lands at sorted position p of a list holding n > 0 elements
// is placed by shifting each larger entry up, one shifted entry per cycle,
// bound by the single read and write port of the list RAM. An element for an
// empty list, or one dropped from a full list, needs only the idle state. The
// last item of a set adds the median reads and result transfer. A two-entry
// queue lets the items channel keep taking transfers while the sorter works.
// Reset clears counts and control state; the list RAM needs no clearing.
// ----------------------------------------------------------------------------
module two_list_median_engine import tlm_pkg::*; #(
  parameter int LIST_CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst,
  tlm_item_if.sink     items,
  tlm_result_if.source results
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  tlm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_ready(q_ready)
  );

  tlm_back #(.LIST_CAPACITY(LIST_CAPACITY)) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_ready(q_ready),
    .results(results)
  );

endmodule
